// ===== hw/rtl/dott_pkg.sv =====
// ----------------------------------------------------------------------------
// dott_pkg
// Shared types and constants for the deadline ordered timer table.
// ----------------------------------------------------------------------------
package dott_pkg;

	localparam int DOTT_NUM_TIMERS = 16;
	localparam int TIME_W          = 48;
	localparam int DELAY_W         = 32;
	localparam int ID_W            = 4;
	localparam int RES_LIMIT       = 16;
	localparam int FIRE_CNT_W      = $clog2(RES_LIMIT);

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_CANCEL   = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_TICK     = 2'd3
	} dott_op_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_EXPIRE = 2'd3
	} dott_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_TICK,
		ST_SCAN,
		ST_FIRE
	} dott_state_t;

	// controller -> datapath
	typedef struct packed {
		logic scan_start;
		logic tick_now;
		logic do_resp;
		logic do_fire;
	} dott_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic scan_end;
		logic best_found;
		logic fire_last;
	} dott_stat_t;

endpackage

// ===== hw/rtl/dott_ctrl.sv =====
// ----------------------------------------------------------------------------
// dott_ctrl
// Sequencer: command response, tick scan passes, expiry emission.
// ----------------------------------------------------------------------------
module dott_ctrl import dott_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	output logic       in_stall,
	input  dott_stat_t stat,
	output dott_ctl_t  ctl
);

	dott_state_t state_q, state_d;
	logic        accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (dott_op_t'(cmd) == CMD_TICK) ? ST_TICK : ST_CMD;
				end
			end
			ST_CMD: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_TICK: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_end) state_d = ST_FIRE;
			end
			ST_FIRE: begin
				if (!stat.best_found) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					state_d = stat.fire_last ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_CMD: begin
				ctl.do_resp = stat.out_free;
			end
			ST_TICK: begin
				ctl.tick_now   = 1'b1;
				ctl.scan_start = 1'b1;
			end
			ST_FIRE: begin
				if (stat.best_found && stat.out_free) begin
					ctl.do_fire    = 1'b1;
					ctl.scan_start = !stat.fire_last;
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dott_datapath.sv =====
// ----------------------------------------------------------------------------
// dott_datapath
// Time counter, slot table, minimum-deadline scan and result register.
// ----------------------------------------------------------------------------
module dott_datapath import dott_pkg::*; #(
	parameter int NUM_TIMERS = DOTT_NUM_TIMERS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic [ID_W-1:0]    timer_id,
	input  logic [DELAY_W-1:0] delay_ms,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         kind,
	output logic [ID_W-1:0]    timer_id_res,
	output logic               flag,
	output logic               last,
	input  dott_ctl_t          ctl,
	output dott_stat_t         stat
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = (IW > ID_W) ? IW + 1 : ID_W + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	// captured command
	dott_op_t           cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [DELAY_W-1:0] delay_q;

	logic [TIME_W-1:0]     now_q;
	logic [NUM_TIMERS-1:0] slot_vld_q;
	logic [TIME_W-1:0]     dl_mem [NUM_TIMERS];

	// scan
	logic              issue_act_q;
	logic [IW-1:0]     issue_idx_q;
	logic              cmp_act_s1;
	logic              cmp_vld_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic [TIME_W-1:0] cmp_dl_s1;
	logic              best_found_q;
	logic              more_q;
	logic [IW-1:0]     best_idx_q;
	logic [TIME_W-1:0] best_dl_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	// output register
	logic            out_valid_q;
	dott_kind_t      kind_q;
	logic [ID_W-1:0] id_res_q;
	logic            flag_q;
	logic            last_q;

	logic              in_table;
	logic [IW-1:0]     widx;
	logic              found;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] new_dl;
	logic              due;
	logic              sched_wr;

	assign in_table = (CW'(id_q) < CW'(NUM_TIMERS));
	assign widx     = IW'(id_q);
	assign found    = in_table && slot_vld_q[widx];
	assign sum      = {1'b0, now_q} + (TIME_W+1)'(delay_q);
	assign new_dl   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
	assign due      = cmp_act_s1 && cmp_vld_s1 && (cmp_dl_s1 <= now_q);
	assign sched_wr = ctl.do_resp && (cmd_q == CMD_SCHEDULE) && in_table;

	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.scan_end   = cmp_act_s1 && (cmp_idx_s1 == LAST_IDX);
	assign stat.best_found = best_found_q;
	assign stat.fire_last  = !more_q || (fire_cnt_q == FIRE_CNT_W'(RES_LIMIT - 1));

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= dott_op_t'(cmd);
			id_q    <= timer_id;
			delay_q <= delay_ms;
		end
	end

	// deadline store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (sched_wr) dl_mem[widx] <= new_dl;
		cmp_dl_s1 <= dl_mem[issue_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			slot_vld_q <= '0;
		end else begin
			if (ctl.tick_now && (now_q != TIME_MAX)) now_q <= now_q + 1'b1;
			if (sched_wr) slot_vld_q[widx] <= 1'b1;
			if (ctl.do_resp && (cmd_q == CMD_CANCEL) && found) slot_vld_q[widx] <= 1'b0;
			if (ctl.do_fire) slot_vld_q[best_idx_q] <= 1'b0;
		end
	end

	// scan pass: issue one slot per cycle, compare in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_act_q  <= 1'b0;
			issue_idx_q  <= '0;
			cmp_act_s1   <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			best_found_q <= 1'b0;
			more_q       <= 1'b0;
			best_idx_q   <= '0;
			best_dl_q    <= '0;
			fire_cnt_q   <= '0;
		end else begin
			if (ctl.scan_start) begin
				issue_act_q  <= 1'b1;
				issue_idx_q  <= '0;
				best_found_q <= 1'b0;
				more_q       <= 1'b0;
			end else if (issue_act_q) begin
				if (issue_idx_q == LAST_IDX) issue_act_q <= 1'b0;
				else issue_idx_q <= issue_idx_q + 1'b1;
			end
			cmp_act_s1 <= issue_act_q && !ctl.scan_start;
			cmp_vld_s1 <= slot_vld_q[issue_idx_q];
			cmp_idx_s1 <= issue_idx_q;
			if (due) begin
				if (best_found_q) more_q <= 1'b1;
				// strict compare keeps the lower id on equal deadlines
				if (!best_found_q || (cmp_dl_s1 < best_dl_q)) begin
					best_found_q <= 1'b1;
					best_idx_q   <= cmp_idx_s1;
					best_dl_q    <= cmp_dl_s1;
				end
			end
			if (ctl.tick_now) fire_cnt_q <= '0;
			else if (ctl.do_fire) fire_cnt_q <= fire_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.do_resp || ctl.do_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_resp) begin
			id_res_q <= id_q;
			last_q   <= 1'b1;
			case (cmd_q)
				CMD_SCHEDULE: begin
					kind_q <= KIND_ACK;
					flag_q <= in_table;
				end
				CMD_CANCEL: begin
					kind_q <= KIND_CANCEL;
					flag_q <= found;
				end
				default: begin
					kind_q <= KIND_QUERY;
					flag_q <= found;
				end
			endcase
		end else if (ctl.do_fire) begin
			kind_q   <= KIND_EXPIRE;
			id_res_q <= ID_W'(best_idx_q);
			flag_q   <= 1'b1;
			last_q   <= stat.fire_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign timer_id_res = id_res_q;
	assign flag         = flag_q;
	assign last         = last_q;

endmodule

// ===== hw/rtl/deadline_ordered_timer_table.sv =====
// Results: schedule, cancel and query results are loaded into the output register by the
// response step that follows acceptance, or later while a held result still occupies it.
// Tick: the counter advances, then each expiry costs one scan pass over the deadline store
// (one slot read per cycle); a tick with F fired timers takes about max(F,1) passes.
// Throughput: one transaction at a time; input stalls from acceptance until the item's
// last result is loaded into the output register, or a tick with nothing due ends its scan.
// Reset: arst_n clears the time counter, all slot valid bits and the controller.
// ----------------------------------------------------------------------------
// deadline_ordered_timer_table
// Timer slots keyed by id with a saturating millisecond counter; ticks emit
// due timers in deadline order, ties broken by lower id.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_table import dott_pkg::*; #(
	parameter int NUM_TIMERS = DOTT_NUM_TIMERS
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [ID_W-1:0]    timer_id,
	input  logic [DELAY_W-1:0] delay_ms,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [ID_W-1:0]    timer_id_res,
	output logic               flag,
	output logic               last
);

	dott_ctl_t  ctl;
	dott_stat_t stat;
	logic       accept;

	// a transaction is taken only while the sequencer is idle
	assign accept = in_valid && !in_stall;

	// Sequencer. Schedule/cancel/query go straight to a response step that
	// waits for the output register. A tick bumps the counter and then runs
	// scan passes; each pass finds the earliest due slot and notes whether a
	// second due slot exists, which with the per-tick fire limit decides the last flag.
	dott_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Datapath: counter, valid bits, deadline store, min search, output reg.
	dott_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.timer_id     (timer_id),
		.delay_ms     (delay_ms),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.timer_id_res (timer_id_res),
		.flag         (flag),
		.last         (last),
		.ctl          (ctl),
		.stat         (stat)
	);

endmodule

// ===== hw/rtl/dott_checker.sv =====
// ----------------------------------------------------------------------------
// dott_checker
// Port-level checks for the deadline ordered timer table.
// ----------------------------------------------------------------------------
module dott_props import dott_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         cmd,
	input logic [ID_W-1:0]    timer_id,
	input logic [DELAY_W-1:0] delay_ms,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic [ID_W-1:0]    timer_id_res,
	input logic               flag,
	input logic               last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) &&
			$stable(timer_id_res) && $stable(flag) && $stable(last))
		else $error("result changed while stalled");

	// one item in flight: busy right after a transaction is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transaction");

	// command answers are single results
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_EXPIRE) |-> last)
		else $error("command result without last");

	// expiries always carry flag
	a_exp_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_EXPIRE) |-> flag)
		else $error("expiry without flag");

endmodule

bind deadline_ordered_timer_table dott_props u_dott_props (.*);
